// ===== rtl/linear_probe_hash_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash table core
// Shared assertion forms, clocked on the rising edge, off while in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht: same-cycle check failed");

// next-cycle implication
`define LPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht: next-cycle check failed");

`endif

// ===== rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Field widths, defaults, result codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int unsigned SLOTS_DEF     = 64;
  localparam int unsigned KEY_BYTES_DEF = 8;
  localparam int unsigned KEY_BYTES_MAX = 8;

  localparam int unsigned KIND_W      = 1;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned PROBE_CNT_W = 7;
  localparam int unsigned HOME_W      = 6;

  // kind codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  // hash unit status toward the controller
  typedef struct packed {
    logic busy;
    logic last;
  } hash_st_t;

endpackage

// ===== rtl/lpht_if.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpht_req_if;
  import lpht_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;

  logic                   valid;
  logic                   ready;
  status_e                status;
  logic [VALUE_W-1:0]     found_value;
  logic [PROBE_CNT_W-1:0] probe_count;
  logic [HOME_W-1:0]      home_slot;

  modport source (output valid, status, found_value, probe_count, home_slot, input ready);
  modport sink   (input valid, status, found_value, probe_count, home_slot, output ready);
endinterface

// ===== rtl/linear_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table core
// Open-addressing dictionary with linear probing over on-chip key and value
// RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command per transfer: kind (insert or search), key and
//   value. rsp_o returns exactly one result per command, in order.
//   After reset the key RAM is swept to zero, one slot a cycle, so req_i.ready
//   stays low until the sweep is done. The value RAM is never cleared.
//   Commands are handled one at a time. After the request transfer the core
//   hashes the key (quotient, then remainder of the byte sum), probes from
//   the home slot, visiting 1..Slots slots (an empty key skips probing), and
//   then loads the result into the output register. The probe loop issues
//   one key RAM read per cycle. The response sits in an output register; a
//   new command is accepted while it waits. If the receiver stalls and a
//   second result is ready, the core holds it and keeps req_i.ready low until
//   the output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_probe_hash_table_core #(
  parameter int unsigned Slots    = lpht_pkg::SLOTS_DEF,
  parameter int unsigned KeyBytes = lpht_pkg::KEY_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpht_req_if.sink   req_i,
  lpht_rsp_if.source rsp_o
);
  import lpht_pkg::*;

  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CntW  = $clog2(Slots + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [SlotW-1:0]       clr_idx_q, clr_idx_d;
  logic [KIND_W-1:0]      kind_q, kind_d;
  logic [VALUE_W-1:0]     value_q, value_d;
  logic [SlotW-1:0]       home_q, home_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [CntW-1:0]        probes_q, probes_d;
  status_e                res_status_q, res_status_d;
  logic [VALUE_W-1:0]     res_found_q, res_found_d;
  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [VALUE_W-1:0]     out_found_q, out_found_d;
  logic [PROBE_CNT_W-1:0] out_probes_q, out_probes_d;
  logic [HOME_W-1:0]      out_home_q, out_home_d;

  // hash unit
  hash_st_t         hash_st;
  logic [SlotW-1:0] hash_home;
  logic [KEY_W-1:0] hash_key;
  logic             req_xfer;

  // RAM ports
  logic               key_we;
  logic [SlotW-1:0]   key_waddr;
  logic [KEY_W-1:0]   key_wdata;
  logic [SlotW-1:0]   raddr;
  logic [KEY_W-1:0]   key_rdata;
  logic               val_we;
  logic [VALUE_W-1:0] val_rdata;

  logic [SlotW-1:0] next_slot;
  logic             is_search;

  assign req_i.ready = (state_q == S_IDLE) && !hash_st.busy;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign is_search   = (kind_q == KIND_SEARCH);

  // linear probe step with wrap
  assign next_slot = (slot_q == SlotW'(Slots - 1)) ? '0 : (slot_q + 1'b1);

  lpht_hash #(
    .Slots   (Slots),
    .KeyBytes(KeyBytes)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (req_xfer),
    .key_i    (req_i.key),
    .hash_st_o(hash_st),
    .home_o   (hash_home),
    .key_o    (hash_key)
  );

  // key RAM: zero means empty slot
  lpht_ram #(
    .Width(KEY_W),
    .Depth(Slots)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .raddr_i(raddr),
    .rdata_o(key_rdata)
  );

  // value RAM: written alongside its key, read at the same address
  lpht_ram #(
    .Width(VALUE_W),
    .Depth(Slots)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(slot_q),
    .wdata_i(value_q),
    .raddr_i(raddr),
    .rdata_o(val_rdata)
  );

  // The only write to a probed slot happens in the last probe cycle, and the
  // next command reads no earlier than its hash finishes, so reads and writes
  // of the same entry never overlap and no forwarding is needed.
  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    kind_d       = kind_q;
    value_d      = value_q;
    home_d       = home_q;
    slot_d       = slot_q;
    probes_d     = probes_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_probes_d = out_probes_q;
    out_home_d   = out_home_q;

    key_we    = 1'b0;
    key_waddr = slot_q;
    key_wdata = hash_key;
    val_we    = 1'b0;
    raddr     = slot_q;

    // response transfer frees the output register
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_idx_q;
        key_wdata = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == SlotW'(Slots - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_xfer) begin
          kind_d   = req_i.kind;
          value_d  = req_i.value;
          probes_d = '0;
          state_d  = S_HASH;
        end
      end

      S_HASH: begin
        // home slot is ready in the last hash cycle: start the first read
        raddr = hash_home;
        if (hash_st.last) begin
          home_d      = hash_home;
          slot_d      = hash_home;
          res_found_d = '0;
          if (hash_key == '0) begin
            // empty key: nothing to probe
            res_status_d = is_search ? STAT_NOT_FOUND : STAT_DUPLICATE;
            state_d      = S_DONE;
          end else begin
            state_d = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        // data for slot_q is on the RAM outputs; the read for the next slot
        // goes out in the same cycle
        raddr = next_slot;
        if (key_rdata == '0) begin
          if (is_search) begin
            res_status_d = STAT_NOT_FOUND;
          end else begin
            key_we       = 1'b1;
            val_we       = 1'b1;
            res_status_d = STAT_INSERTED;
          end
          state_d = S_DONE;
        end else begin
          probes_d = probes_q + CntW'(kind_q);
          if (key_rdata == hash_key) begin
            res_status_d = is_search ? STAT_FOUND : STAT_DUPLICATE;
            res_found_d  = is_search ? val_rdata : '0;
            state_d      = S_DONE;
          end else if (next_slot == home_q) begin
            // wrapped all the way around
            res_status_d = is_search ? STAT_NOT_FOUND : STAT_FULL;
            state_d      = S_DONE;
          end else begin
            slot_d = next_slot;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_probes_d = PROBE_CNT_W'(probes_q);
          out_home_d   = HOME_W'(home_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_idx_q    <= '0;
      kind_q       <= '0;
      value_q      <= '0;
      home_q       <= '0;
      slot_q       <= '0;
      probes_q     <= '0;
      res_status_q <= STAT_INSERTED;
      res_found_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_INSERTED;
      out_found_q  <= '0;
      out_probes_q <= '0;
      out_home_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_idx_q    <= clr_idx_d;
      kind_q       <= kind_d;
      value_q      <= value_d;
      home_q       <= home_d;
      slot_q       <= slot_d;
      probes_q     <= probes_d;
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_probes_q <= out_probes_d;
      out_home_q   <= out_home_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.found_value = out_found_q;
  assign rsp_o.probe_count = out_probes_q;
  assign rsp_o.home_slot   = out_home_q;

endmodule

// ===== rtl/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_ram #(
  parameter  int unsigned Width = 64,
  parameter  int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/lpht_hash.sv =====
// ----------------------------------------------------------------------------
// Hash unit
// Trims the key at its first zero byte or past KeyBytes, sums the bytes and
// reduces the sum modulo the slot count: reciprocal multiply for the quotient
// in the first phase, multiply-back and subtract for the remainder in the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_hash #(
  parameter  int unsigned Slots    = lpht_pkg::SLOTS_DEF,
  parameter  int unsigned KeyBytes = lpht_pkg::KEY_BYTES_DEF,
  localparam int unsigned SlotW    = $clog2(Slots)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [lpht_pkg::KEY_W-1:0] key_i,
  output lpht_pkg::hash_st_t       hash_st_o,
  output logic [SlotW-1:0]         home_o,
  output logic [lpht_pkg::KEY_W-1:0] key_o
);
  import lpht_pkg::*;

  localparam int unsigned SumW   = $clog2(KeyBytes * 255 + 1);
  // floor(sum / Slots) == (sum * Recip) >> Shift for every sum below 2**SumW
  localparam int unsigned Shift  = SumW + SlotW;
  localparam int unsigned Recip  = (32'd1 << Shift) / Slots + 1;
  localparam int unsigned RecipW = SumW + 2;
  localparam int unsigned ProdW  = SumW + RecipW;

  logic             alive_c;
  logic [7:0]       byte_c;
  logic [SumW-1:0]  sum_c;
  logic [KEY_W-1:0] kept_c;
  logic [ProdW-1:0] prod_c;
  logic [SumW-1:0]  quo_c;
  logic [SumW-1:0]  rem_c;
  logic             last_c;

  logic             busy_q;
  logic             phase_q;  // 0: quotient, 1: remainder
  logic [SumW-1:0]  sum_q;
  logic [SumW-1:0]  quo_q;
  logic [KEY_W-1:0] key_q;

  // trim after first zero byte or past the key length, and sum
  always_comb begin
    alive_c = 1'b1;
    sum_c   = '0;
    kept_c  = '0;
    byte_c  = '0;
    for (int n = 0; n < KEY_BYTES_MAX; n++) begin
      byte_c = key_i[8*n +: 8];
      if ((n < KeyBytes) && alive_c && (byte_c != 8'd0)) begin
        kept_c[8*n +: 8] = byte_c;
        sum_c            = sum_c + SumW'(byte_c);
      end else begin
        alive_c = 1'b0;
      end
    end
  end

  assign prod_c = ProdW'(sum_q) * ProdW'(Recip);
  assign quo_c  = SumW'(prod_c >> Shift);
  assign rem_c  = sum_q - SumW'(quo_q * Slots);
  assign last_c = busy_q && phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      sum_q   <= '0;
      quo_q   <= '0;
      key_q   <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      phase_q <= 1'b0;
      sum_q   <= sum_c;
      key_q   <= kept_c;
    end else if (busy_q) begin
      if (!phase_q) begin
        quo_q   <= quo_c;
        phase_q <= 1'b1;
      end else begin
        busy_q  <= 1'b0;
        phase_q <= 1'b0;
      end
    end
  end

  assign hash_st_o = '{busy: busy_q, last: last_c};
  assign home_o    = SlotW'(rem_c);
  assign key_o     = key_q;

endmodule

// ===== rtl/lpht_checker.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_probe_hash_table_core_defines.svh"

module lpht_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input lpht_pkg::status_e                rsp_status_i,
  input logic [lpht_pkg::VALUE_W-1:0]     rsp_found_value_i,
  input logic [lpht_pkg::PROBE_CNT_W-1:0] rsp_probe_count_i
);
  import lpht_pkg::*;

  // response holds while stalled
  `LPHT_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `LPHT_ASSERT_NXT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable(rsp_found_value_i))

  // one command in flight: ready drops after each request transfer
  `LPHT_ASSERT_NXT(a_one_cmd, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // value only on a hit
  `LPHT_ASSERT_IMP(a_val_hit, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != STAT_FOUND), rsp_found_value_i == '0)

  // insert results carry no probe count
  `LPHT_ASSERT_IMP(a_ins_cnt, clk_i, rst_ni, rsp_valid_i && ((rsp_status_i == STAT_INSERTED) || (rsp_status_i == STAT_DUPLICATE) || (rsp_status_i == STAT_FULL)), rsp_probe_count_i == '0)

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_found_value_i(rsp_o.found_value),
  .rsp_probe_count_i(rsp_o.probe_count)
);
